@@ rtl/core/hpid_pkg.sv @@
// hpid_pkg: shared widths, constants and register index codes of the heading pid controller
`timescale 1ns / 1ps

package hpid_pkg;

  localparam int unsigned ANGLE_W    = 32;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned VEL_W      = 8;
  localparam int unsigned DT_W       = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned INTEG_W    = 48;

  // ms per second times q16 one, divisor of the integral increment
  localparam int unsigned      IDIV_W        = 26;
  localparam logic [IDIV_W-1:0] INT_SCALE_DEN = 26'd65536000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_ANGLE = 3'd0,
    CFG_PROP_GAIN    = 3'd1,
    CFG_INT_GAIN     = 3'd2,
    CFG_DER_GAIN     = 3'd3,
    CFG_BASE_VEL     = 3'd4
  } cfg_idx_e;

endpackage

@@ rtl/core/hpid_if.sv @@
// hpid_if: sample, result and configuration channel interfaces
`timescale 1ns / 1ps

interface hpid_smp_if;
  import hpid_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [ANGLE_W-1:0]  measured_rotation;
  logic        [DT_W-1:0]     elapsed_ms;
  modport source (output valid, measured_rotation, elapsed_ms, input ready);
  modport sink   (input valid, measured_rotation, elapsed_ms, output ready);
endinterface

interface hpid_res_if;
  import hpid_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [ANGLE_W-1:0]  correction;
  logic signed [VEL_W-1:0]    velocity_command;
  logic                       saturated;
  modport source (output valid, correction, velocity_command, saturated, input ready);
  modport sink   (input valid, correction, velocity_command, saturated, output ready);
endinterface

interface hpid_cfg_if;
  import hpid_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   idx;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

@@ rtl/core/heading_pid_controller.sv @@
// heading_pid_controller: pid heading regulator with a variable time step
//
// Usage: samples (measured_rotation, elapsed_ms) arrive on smp_i, one result
// (correction, velocity_command, saturated) leaves on res_o per sample. The
// configuration channel cfg_i writes the target angle, the three Q8.16 gains
// and the forward drive percent; any write to a known register clears the
// integral and the previous error. A write to an unknown index is dropped.
// The arithmetic runs through one shift-add multiplier and one restoring
// divider, both retiring one bit per cycle. A sample passes in order through
// the P product, the kd*1000*delta product, the D quotient, the ki*dt and
// error*ki*dt products, the I quotient, then accumulation and saturation;
// when elapsed_ms is zero only the P product, accumulation and saturation
// run. One sample is in work at a time, so a new sample is taken only after
// the last one is through the datapath; smp_i is ready whenever the datapath
// is free, also while a finished result waits in the output register. If
// the receiver stalls, the next result waits in its last step until the
// output register empties. Reset clears all registers, the integral and the
// previous error to zero.
`timescale 1ns / 1ps

module heading_pid_controller (
  input  logic         clk_i,
  input  logic         rst_ni,
  hpid_smp_if.sink     smp_i,
  hpid_res_if.source   res_o,
  hpid_cfg_if.sink     cfg_i
);
  import hpid_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_KD,
    ST_DIV_D,
    ST_MUL_KIDT,
    ST_MUL_I,
    ST_DIV_I,
    ST_INTEG,
    ST_SUM
  } state_e;

  localparam int unsigned ERR_W  = ANGLE_W + 1;   // error and magnitudes
  localparam int unsigned MHI_W  = ERR_W + 1;     // multiplier upper half
  localparam int unsigned MLO_W  = 40;            // multiplier lower half
  localparam int unsigned QSR_W  = 50;            // divider dividend/quotient
  localparam int unsigned P_W    = 41;
  localparam int unsigned D_W    = QSR_W + 1;
  localparam int unsigned INC_W  = 47;
  localparam int unsigned PD_W   = D_W + 1;
  localparam int unsigned SUM_W  = PD_W + 1;

  localparam logic [5:0] CNT_P    = 6'd23;
  localparam logic [5:0] CNT_KD   = 6'd32;
  localparam logic [5:0] CNT_DD   = 6'd49;
  localparam logic [5:0] CNT_KIDT = 6'd15;
  localparam logic [5:0] CNT_I    = 6'd39;
  localparam logic [5:0] CNT_DI   = 6'd45;

  localparam logic [ANGLE_W-1:0] CORR_MAX = 32'h7FFF_FFFF;
  localparam logic [ANGLE_W-1:0] CORR_MIN = 32'h8000_0000;
  localparam logic [INTEG_W-1:0] INTEG_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [INTEG_W-1:0] INTEG_MIN = 48'h8000_0000_0000;

  state_e                state_q;
  logic [5:0]            cnt_q;

  logic [ANGLE_W-1:0]    target_q;
  logic [GAIN_W-1:0]     kp_q, ki_q, kd_q;
  logic [VEL_W-1:0]      base_vel_q;
  logic [INTEG_W-1:0]    integ_q;
  logic [ERR_W-1:0]      last_err_q;

  logic [DT_W-1:0]       dt_q;
  logic [ERR_W-1:0]      err_mag_q;
  logic [ERR_W-1:0]      de_mag_q;
  logic                  p_neg_q, d_neg_q, i_neg_q;

  logic [ERR_W-1:0]      mul_m_q;
  logic [MHI_W-1:0]      mul_hi_q, mul_hi_d, mul_sum;
  logic [MLO_W-1:0]      mul_lo_q, mul_lo_d;

  logic [IDIV_W-1:0]     div_q;
  logic [IDIV_W-1:0]     rem_q, rem_d;
  logic [QSR_W-1:0]      qsr_q, qsr_d;
  logic [IDIV_W:0]       div_trial, div_diff;
  logic                  div_ge;

  logic [P_W-1:0]        p_q;
  logic [D_W-1:0]        d_q;
  logic [PD_W-1:0]       pd_q;

  logic                  out_valid_q;
  logic [ANGLE_W-1:0]    corr_q;
  logic [VEL_W-1:0]      vel_q;
  logic                  sat_q;

  logic                  smp_acc, cfg_acc, cfg_known, out_free, last_step;
  logic [ERR_W-1:0]      err_w, err_mag_w, de_mag_w;
  logic [ERR_W:0]        de_w, de_abs_w;
  logic [GAIN_W-1:0]     kp_mag, ki_mag, kd_mag;
  logic [ERR_W:0]        kd1000_w;
  logic [P_W-2:0]        p_mag;
  logic [P_W-1:0]        p_val;
  logic [D_W-1:0]        d_val;
  logic [INC_W-1:0]      inc_val;
  logic [INTEG_W:0]      integ_sum;
  logic [INTEG_W-1:0]    integ_d;
  logic [PD_W-1:0]       pd_sum;
  logic [SUM_W-1:0]      corr_sum;
  logic                  corr_ovf;

  assign smp_acc   = smp_i.valid && smp_i.ready;
  assign cfg_acc   = cfg_i.valid && cfg_i.ready;
  assign out_free  = !out_valid_q || res_o.ready;
  assign last_step = (cnt_q == '0);

  assign smp_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign res_o.valid            = out_valid_q;
  assign res_o.correction       = corr_q;
  assign res_o.velocity_command = vel_q;
  assign res_o.saturated        = sat_q;

  always_comb begin
    cfg_known = 1'b0;
    unique case (cfg_idx_e'(cfg_i.idx)) inside
      CFG_TARGET_ANGLE, CFG_PROP_GAIN, CFG_INT_GAIN, CFG_DER_GAIN, CFG_BASE_VEL:
        cfg_known = 1'b1;
      default: cfg_known = 1'b0;
    endcase
  end

  // error, error delta and operand magnitudes
  always_comb begin
    err_w     = {target_q[ANGLE_W-1], target_q}
              - {smp_i.measured_rotation[ANGLE_W-1], smp_i.measured_rotation};
    err_mag_w = err_w[ERR_W-1] ? (~err_w + 1'b1) : err_w;
    de_w      = {err_w[ERR_W-1], err_w} - {last_err_q[ERR_W-1], last_err_q};
    de_abs_w  = de_w[ERR_W] ? (~de_w + 1'b1) : de_w;
    de_mag_w  = de_abs_w[ERR_W-1:0];
    kp_mag    = kp_q[GAIN_W-1] ? (~kp_q + 1'b1) : kp_q;
    ki_mag    = ki_q[GAIN_W-1] ? (~ki_q + 1'b1) : ki_q;
    kd_mag    = kd_q[GAIN_W-1] ? (~kd_q + 1'b1) : kd_q;
    // x * 1000 = x * 1024 - x * 16 - x * 8
    kd1000_w  = ({10'd0, kd_mag} << 10) - ({10'd0, kd_mag} << 4)
              - ({10'd0, kd_mag} << 3);
  end

  // one shift-add multiplier step: lsb of the lower half selects the add
  always_comb begin
    mul_sum  = mul_hi_q + (mul_lo_q[0] ? {1'b0, mul_m_q} : '0);
    mul_hi_d = {1'b0, mul_sum[MHI_W-1:1]};
    mul_lo_d = {mul_sum[0], mul_lo_q[MLO_W-1:1]};
  end

  // one restoring divider step
  always_comb begin
    div_trial = {rem_q, qsr_q[QSR_W-1]};
    div_diff  = div_trial - {1'b0, div_q};
    div_ge    = (div_trial >= {1'b0, div_q});
    rem_d     = div_ge ? div_diff[IDIV_W-1:0] : div_trial[IDIV_W-1:0];
    qsr_d     = {qsr_q[QSR_W-2:0], div_ge};
  end

  // signed terms, integral update and final sum
  always_comb begin
    p_mag     = {mul_hi_d[31:0], mul_lo_d[MLO_W-1:32]};
    p_val     = p_neg_q ? (~{1'b0, p_mag} + 1'b1) : {1'b0, p_mag};
    d_val     = d_neg_q ? (~{1'b0, qsr_d} + 1'b1) : {1'b0, qsr_d};
    inc_val   = i_neg_q ? (~{1'b0, qsr_q[INC_W-2:0]} + 1'b1)
                        : {1'b0, qsr_q[INC_W-2:0]};
    integ_sum = {integ_q[INTEG_W-1], integ_q}
              + {{(INTEG_W + 1 - INC_W){inc_val[INC_W-1]}}, inc_val};
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_d = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
    end else begin
      integ_d = integ_sum[INTEG_W-1:0];
    end
    pd_sum    = {{(PD_W - P_W){p_q[P_W-1]}}, p_q} + {d_q[D_W-1], d_q};
    corr_sum  = {pd_q[PD_W-1], pd_q}
              + {{(SUM_W - INTEG_W){integ_q[INTEG_W-1]}}, integ_q};
    corr_ovf  = (corr_sum[SUM_W-1:ANGLE_W-1] != {(SUM_W - ANGLE_W + 1){corr_sum[ANGLE_W-1]}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      target_q    <= '0;
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      base_vel_q  <= '0;
      integ_q     <= '0;
      last_err_q  <= '0;
      dt_q        <= '0;
      err_mag_q   <= '0;
      de_mag_q    <= '0;
      p_neg_q     <= 1'b0;
      d_neg_q     <= 1'b0;
      i_neg_q     <= 1'b0;
      mul_m_q     <= '0;
      mul_hi_q    <= '0;
      mul_lo_q    <= '0;
      div_q       <= '0;
      rem_q       <= '0;
      qsr_q       <= '0;
      p_q         <= '0;
      d_q         <= '0;
      pd_q        <= '0;
      out_valid_q <= 1'b0;
      corr_q      <= '0;
      vel_q       <= '0;
      sat_q       <= 1'b0;
    end else begin
      if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (smp_acc) begin
            dt_q       <= smp_i.elapsed_ms;
            err_mag_q  <= err_mag_w;
            de_mag_q   <= de_mag_w;
            p_neg_q    <= err_w[ERR_W-1] ^ kp_q[GAIN_W-1];
            i_neg_q    <= err_w[ERR_W-1] ^ ki_q[GAIN_W-1];
            d_neg_q    <= de_w[ERR_W] ^ kd_q[GAIN_W-1];
            last_err_q <= err_w;
            mul_m_q    <= err_mag_w;
            mul_hi_q   <= '0;
            mul_lo_q   <= {{(MLO_W - GAIN_W){1'b0}}, kp_mag};
            cnt_q      <= CNT_P;
            state_q    <= ST_MUL_P;
          end
        end
        ST_MUL_P: begin
          mul_hi_q <= mul_hi_d;
          mul_lo_q <= mul_lo_d;
          cnt_q    <= cnt_q - 1'b1;
          if (last_step) begin
            p_q <= p_val;
            if (dt_q == '0) begin
              // no elapsed time: no derivative and no integral increment
              d_q     <= '0;
              qsr_q   <= '0;
              state_q <= ST_INTEG;
            end else begin
              mul_m_q  <= de_mag_q;
              mul_hi_q <= '0;
              mul_lo_q <= {{(MLO_W - ERR_W){1'b0}}, kd1000_w[ERR_W-1:0]};
              cnt_q    <= CNT_KD;
              state_q  <= ST_MUL_KD;
            end
          end
        end
        ST_MUL_KD: begin
          mul_hi_q <= mul_hi_d;
          mul_lo_q <= mul_lo_d;
          cnt_q    <= cnt_q - 1'b1;
          if (last_step) begin
            // numerator already scaled down by the q16 one
            qsr_q   <= {mul_hi_d[ERR_W-1:0], mul_lo_d[MLO_W-1:23]};
            rem_q   <= '0;
            div_q   <= {{(IDIV_W - DT_W){1'b0}}, dt_q};
            cnt_q   <= CNT_DD;
            state_q <= ST_DIV_D;
          end
        end
        ST_DIV_D: begin
          rem_q <= rem_d;
          qsr_q <= qsr_d;
          cnt_q <= cnt_q - 1'b1;
          if (last_step) begin
            d_q      <= d_val;
            mul_m_q  <= {{(ERR_W - GAIN_W){1'b0}}, ki_mag};
            mul_hi_q <= '0;
            mul_lo_q <= {{(MLO_W - DT_W){1'b0}}, dt_q};
            cnt_q    <= CNT_KIDT;
            state_q  <= ST_MUL_KIDT;
          end
        end
        ST_MUL_KIDT: begin
          mul_hi_q <= mul_hi_d;
          mul_lo_q <= mul_lo_d;
          cnt_q    <= cnt_q - 1'b1;
          if (last_step) begin
            // ki * dt becomes the serial operand of the next product
            mul_m_q  <= err_mag_q;
            mul_hi_q <= '0;
            mul_lo_q <= {mul_hi_d[23:0], mul_lo_d[MLO_W-1:24]};
            cnt_q    <= CNT_I;
            state_q  <= ST_MUL_I;
          end
        end
        ST_MUL_I: begin
          mul_hi_q <= mul_hi_d;
          mul_lo_q <= mul_lo_d;
          cnt_q    <= cnt_q - 1'b1;
          if (last_step) begin
            // top bits stay below the divisor, so they seed the remainder
            rem_q   <= {1'b0, mul_hi_d[30:6]};
            qsr_q   <= {mul_hi_d[5:0], mul_lo_d, 4'd0};
            div_q   <= INT_SCALE_DEN;
            cnt_q   <= CNT_DI;
            state_q <= ST_DIV_I;
          end
        end
        ST_DIV_I: begin
          rem_q <= rem_d;
          qsr_q <= qsr_d;
          cnt_q <= cnt_q - 1'b1;
          if (last_step) begin
            state_q <= ST_INTEG;
          end
        end
        ST_INTEG: begin
          integ_q <= integ_d;
          pd_q    <= pd_sum;
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            vel_q       <= base_vel_q;
            sat_q       <= corr_ovf;
            if (corr_ovf) begin
              corr_q <= corr_sum[SUM_W-1] ? CORR_MIN : CORR_MAX;
            end else begin
              corr_q <= corr_sum[ANGLE_W-1:0];
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // register writes start a new task
      if (cfg_acc && cfg_known) begin
        integ_q    <= '0;
        last_err_q <= '0;
        unique case (cfg_idx_e'(cfg_i.idx))
          CFG_TARGET_ANGLE: target_q   <= cfg_i.data[ANGLE_W-1:0];
          CFG_PROP_GAIN:    kp_q       <= cfg_i.data[GAIN_W-1:0];
          CFG_INT_GAIN:     ki_q       <= cfg_i.data[GAIN_W-1:0];
          CFG_DER_GAIN:     kd_q       <= cfg_i.data[GAIN_W-1:0];
          CFG_BASE_VEL:     base_vel_q <= cfg_i.data[VEL_W-1:0];
          default:          base_vel_q <= base_vel_q;
        endcase
      end
    end
  end

endmodule
